// File: rtl/pcbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbs_pkg
// Shared types and constants of the plate character box selector.
// ----------------------------------------------------------------------------
package pcbs_pkg;

   localparam int COORD_BITS    = 12;
   localparam int HGT_BITS      = COORD_BITS + 1;
   localparam int MAX_BOXES     = 32;
   localparam int IDX_BITS      = $clog2(MAX_BOXES);
   localparam int CNT_BITS      = $clog2(MAX_BOXES + 1);

   // queue depth must be a power of two, pointers wrap naturally
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam int RATIO_BITS    = 8;
   localparam int PCT_BITS      = 10;
   localparam int RATIO_PROD_BITS = RATIO_BITS + COORD_BITS;
   localparam int SIZE_PROD_BITS  = PCT_BITS + COORD_BITS;
   localparam int RATIO_SCALE   = 10;
   localparam int PCT_SCALE     = 1000;
   localparam int EXPAND_MARGIN = 4;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 12;

   localparam logic [CSR_IDX_BITS-1:0] CSR_RATIO_LIMIT  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VAR_LIMIT    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_ROWS   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_COLS   = 3'd5;

   typedef struct packed {
      logic [RATIO_BITS-1:0] ratio_limit_tenths;
      logic [PCT_BITS-1:0]   min_height_pct_tenths;
      logic [PCT_BITS-1:0]   min_width_pct_tenths;
      logic [COORD_BITS-1:0] height_variation_limit;
      logic [COORD_BITS-1:0] image_rows;
      logic [COORD_BITS-1:0] image_cols;
   } csr_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] h;
      logic [COORD_BITS-1:0] cx;
   } box_type;

   typedef struct packed {
      logic    keep;
      logic    last;
      box_type box;
   } item_type;

   typedef struct packed {
      logic                  valid;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [HGT_BITS-1:0]   h;
      logic                  last;
   } crop_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_INS_WALK,
      BK_INS_PLACE,
      BK_EMIT,
      BK_FLUSH
   } back_state_type;

endpackage

// File: rtl/plate_character_box_selector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plate_character_box_selector_core
// Keeps plausible character boxes, sorts them by centroid column and emits
// the crop rectangles of the selected ones at the end of each frame.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests: one candidate box per request, taken on a rising edge with
//    start high and busy low. The request marked req_last_box closes a frame.
//  - Registers: csr_write_enable, csr_index, csr_write_data; write only while
//    the block is idle.
//  - Responses: each crop is presented for one cycle with rsp_strobe high;
//    the receiver must take it. The final crop of a frame has rsp_last_crop
//    set; a frame with no selected box gives one crop with rsp_crop_valid low.
//  - Timing: a request is registered for classification, then waits in a
//    two-entry queue for the store sequencer. A kept box is inserted into a
//    non-empty store by the one-entry-a-cycle shift walk through the
//    single-write box store. On the last request, emission makes one store
//    read per cycle; each selected crop is held back and strobed once the
//    next selected read is in, and the final crop is strobed from the flush
//    state with rsp_last_crop set.
//  - busy rises while the classification stage holds a request that the
//    queue cannot take.
//  - Reset: queue, store count and tallest height clear; registers return to
//    their defaults. The store needs no clearing pass.
// ----------------------------------------------------------------------------
module plate_character_box_selector_core import pcbs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_box_present,
   input  logic [COORD_BITS-1:0]    req_box_x,
   input  logic [COORD_BITS-1:0]    req_box_y,
   input  logic [COORD_BITS-1:0]    req_box_width,
   input  logic [COORD_BITS-1:0]    req_box_height,
   input  logic [COORD_BITS-1:0]    req_centroid_col,
   input  logic                     req_last_box,
   output logic                     rsp_strobe,
   output logic                     rsp_crop_valid,
   output logic [COORD_BITS-1:0]    rsp_crop_x,
   output logic [COORD_BITS-1:0]    rsp_crop_y,
   output logic [COORD_BITS-1:0]    rsp_crop_width,
   output logic [HGT_BITS-1:0]      rsp_crop_height,
   output logic                     rsp_last_crop,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data
);

   csr_type  csr_ff, csr_in;
   logic     push, queue_full, queue_valid, pop;
   item_type push_item, head;
   crop_type out_crop;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_RATIO_LIMIT: csr_in.ratio_limit_tenths     = csr_write_data[RATIO_BITS-1:0];
            CSR_MIN_HEIGHT:  csr_in.min_height_pct_tenths  = csr_write_data[PCT_BITS-1:0];
            CSR_MIN_WIDTH:   csr_in.min_width_pct_tenths   = csr_write_data[PCT_BITS-1:0];
            CSR_VAR_LIMIT:   csr_in.height_variation_limit = csr_write_data[COORD_BITS-1:0];
            CSR_IMAGE_ROWS:  csr_in.image_rows             = csr_write_data[COORD_BITS-1:0];
            CSR_IMAGE_COLS:  csr_in.image_cols             = csr_write_data[COORD_BITS-1:0];
            default: begin
               csr_in = csr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.ratio_limit_tenths     <= RATIO_BITS'(32);
         csr_ff.min_height_pct_tenths  <= PCT_BITS'(144);
         csr_ff.min_width_pct_tenths   <= PCT_BITS'(50);
         csr_ff.height_variation_limit <= COORD_BITS'(7);
         csr_ff.image_rows             <= COORD_BITS'(480);
         csr_ff.image_cols             <= COORD_BITS'(640);
      end else begin
         csr_ff <= csr_in;
      end
   end

   pcbs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_box_present  (req_box_present),
      .req_box_x        (req_box_x),
      .req_box_y        (req_box_y),
      .req_box_width    (req_box_width),
      .req_box_height   (req_box_height),
      .req_centroid_col (req_centroid_col),
      .req_last_box     (req_last_box),
      .csr              (csr_ff),
      .queue_full       (queue_full),
      .push             (push),
      .push_item        (push_item)
   );

   pcbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .not_empty (queue_valid),
      .pop       (pop),
      .head      (head)
   );

   pcbs_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .queue_valid            (queue_valid),
      .head                   (head),
      .pop                    (pop),
      .height_variation_limit (csr_ff.height_variation_limit),
      .out_strobe             (rsp_strobe),
      .out_crop               (out_crop)
   );

   assign rsp_crop_valid  = out_crop.valid;
   assign rsp_crop_x      = out_crop.x;
   assign rsp_crop_y      = out_crop.y;
   assign rsp_crop_width  = out_crop.w;
   assign rsp_crop_height = out_crop.h;
   assign rsp_last_crop   = out_crop.last;

endmodule

// File: rtl/pcbs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbs_front
// Request register and box classification (ratio and size tests).
// ----------------------------------------------------------------------------
module pcbs_front import pcbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_box_present,
   input  logic [COORD_BITS-1:0] req_box_x,
   input  logic [COORD_BITS-1:0] req_box_y,
   input  logic [COORD_BITS-1:0] req_box_width,
   input  logic [COORD_BITS-1:0] req_box_height,
   input  logic [COORD_BITS-1:0] req_centroid_col,
   input  logic                  req_last_box,
   input  csr_type               csr,
   input  logic                  queue_full,
   output logic                  push,
   output item_type              push_item
);

   logic                       valid_ff, valid_in;
   logic                       present_ff;
   logic                       last_ff;
   box_type                    box_ff;
   logic                       accept;
   logic [COORD_BITS-1:0]      lng, sht;
   logic [RATIO_PROD_BITS-1:0] lng_scaled, ratio_bound;
   logic [SIZE_PROD_BITS-1:0]  h_scaled, h_bound, w_scaled, w_bound;
   logic                       keep;

   assign busy   = valid_ff & queue_full;
   assign accept = start & ~busy;

   assign lng = (box_ff.h > box_ff.w) ? box_ff.h : box_ff.w;
   assign sht = (box_ff.h > box_ff.w) ? box_ff.w : box_ff.h;

   assign lng_scaled  = RATIO_PROD_BITS'(lng) * RATIO_PROD_BITS'(RATIO_SCALE);
   assign ratio_bound = RATIO_PROD_BITS'(csr.ratio_limit_tenths) * RATIO_PROD_BITS'(sht);
   assign h_scaled    = SIZE_PROD_BITS'(box_ff.h) * SIZE_PROD_BITS'(PCT_SCALE);
   assign h_bound     = SIZE_PROD_BITS'(csr.min_height_pct_tenths)
                        * SIZE_PROD_BITS'(csr.image_rows);
   assign w_scaled    = SIZE_PROD_BITS'(box_ff.w) * SIZE_PROD_BITS'(PCT_SCALE);
   assign w_bound     = SIZE_PROD_BITS'(csr.min_width_pct_tenths)
                        * SIZE_PROD_BITS'(csr.image_cols);

   assign keep = present_ff & (lng_scaled < ratio_bound) & (h_scaled > h_bound)
                 & (w_scaled > w_bound);

   // items with no kept box and no end mark have no effect and are dropped
   assign push           = valid_ff & ~queue_full & (keep | last_ff);
   assign push_item.keep = keep;
   assign push_item.last = last_ff;
   assign push_item.box  = box_ff;

   assign valid_in = accept | (valid_ff & queue_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         present_ff <= req_box_present;
         last_ff    <= req_last_box;
         box_ff.x   <= req_box_x;
         box_ff.y   <= req_box_y;
         box_ff.w   <= req_box_width;
         box_ff.h   <= req_box_height;
         box_ff.cx  <= req_centroid_col;
      end
   end

endmodule

// File: rtl/pcbs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbs_queue
// Short request queue between classification and the store sequencer.
// ----------------------------------------------------------------------------
module pcbs_queue import pcbs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   output logic     not_empty,
   input  logic     pop,
   output item_type head
);

   item_type             data_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = data_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;

   assign wr_ptr_in = do_push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("request pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("request popped from empty queue");

endmodule

// File: rtl/pcbs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbs_back
// Sorted box store: insertion walk on kept boxes into a non-empty store, crop emission on frame end.
// ----------------------------------------------------------------------------
module pcbs_back import pcbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_valid,
   input  item_type              head,
   output logic                  pop,
   input  logic [COORD_BITS-1:0] height_variation_limit,
   output logic                  out_strobe,
   output crop_type              out_crop
);

   back_state_type        state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [COORD_BITS-1:0] tallest_ff, tallest_in;
   logic [CNT_BITS-1:0]   pos_ff, pos_in;
   item_type              cur_ff, cur_in;
   logic [CNT_BITS-1:0]   emit_idx_ff, emit_idx_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic                  pend_valid_ff, pend_valid_in;
   crop_type              pend_ff, pend_in;
   logic                  out_strobe_ff, out_strobe_in;
   crop_type              out_ff, out_in;

   box_type               store_ff [MAX_BOXES];
   box_type               rd_a_ff, rd_b_ff;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   box_type               wr_data;
   logic [IDX_BITS-1:0]   rd_a_addr, rd_b_addr;

   logic                  take, has_room, greater, issue;
   logic [CNT_BITS-1:0]   idx_next, nb_idx;
   logic                  qualify, expand;
   logic [COORD_BITS-1:0] diff, y_adj;
   logic [HGT_BITS-1:0]   h_adj;
   crop_type              new_crop;

   assign has_room = (count_ff < CNT_BITS'(MAX_BOXES));
   assign take     = head.keep & has_room;
   assign greater  = (rd_a_ff.cx > cur_ff.box.cx);
   assign issue    = (emit_idx_ff < count_ff);
   assign idx_next = emit_idx_ff + CNT_BITS'(1);

   always_comb begin
      if (idx_next < count_ff) begin
         nb_idx = idx_next;
      end else if (emit_idx_ff != '0) begin
         nb_idx = emit_idx_ff - CNT_BITS'(1);
      end else begin
         nb_idx = emit_idx_ff;
      end
   end

   // crop of the entry read last cycle, neighbor on port b
   assign qualify = !({rd_a_ff.h, 1'b0} < {1'b0, tallest_ff});
   assign diff    = (tallest_ff > rd_a_ff.h) ? tallest_ff - rd_a_ff.h
                                             : rd_a_ff.h - tallest_ff;
   assign expand  = (diff > height_variation_limit);
   assign y_adj   = (rd_b_ff.y >= COORD_BITS'(EXPAND_MARGIN))
                    ? rd_b_ff.y - COORD_BITS'(EXPAND_MARGIN) : '0;
   assign h_adj   = {1'b0, rd_b_ff.h} + HGT_BITS'(EXPAND_MARGIN);

   assign new_crop.valid = 1'b1;
   assign new_crop.x     = rd_a_ff.x;
   assign new_crop.y     = expand ? y_adj : rd_a_ff.y;
   assign new_crop.w     = rd_a_ff.w;
   assign new_crop.h     = expand ? h_adj : {1'b0, rd_a_ff.h};
   assign new_crop.last  = 1'b0;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (queue_valid) begin
               if (take && count_ff != '0) begin
                  state_in = BK_INS_WALK;
               end else if (head.last) begin
                  state_in = BK_EMIT;
               end
            end
         end
         BK_INS_WALK: begin
            if (greater) begin
               if (pos_ff == CNT_BITS'(1)) begin
                  state_in = BK_INS_PLACE;
               end
            end else begin
               state_in = cur_ff.last ? BK_EMIT : BK_IDLE;
            end
         end
         BK_INS_PLACE: begin
            state_in = cur_ff.last ? BK_EMIT : BK_IDLE;
         end
         BK_EMIT: begin
            if (!issue && !rd_valid_ff) begin
               state_in = BK_FLUSH;
            end
         end
         BK_FLUSH: begin
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop           = 1'b0;
      count_in      = count_ff;
      tallest_in    = tallest_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      emit_idx_in   = '0;
      rd_valid_in   = 1'b0;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_strobe_in = 1'b0;
      out_in        = out_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = cur_ff.box;
      rd_a_addr     = '0;
      rd_b_addr     = '0;
      case (state_ff)
         BK_IDLE: begin
            if (queue_valid) begin
               pop    = 1'b1;
               cur_in = head;
               if (take) begin
                  if (head.box.h > tallest_ff) begin
                     tallest_in = head.box.h;
                  end
                  if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_data  = head.box;
                     count_in = CNT_BITS'(1);
                  end else begin
                     rd_a_addr = IDX_BITS'(count_ff - CNT_BITS'(1));
                     pos_in    = count_ff;
                  end
               end
            end
         end
         BK_INS_WALK: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[IDX_BITS-1:0];
            if (greater) begin
               wr_data   = rd_a_ff;
               pos_in    = pos_ff - CNT_BITS'(1);
               rd_a_addr = IDX_BITS'(pos_ff - CNT_BITS'(2));
            end else begin
               wr_data  = cur_ff.box;
               count_in = count_ff + CNT_BITS'(1);
            end
         end
         BK_INS_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[IDX_BITS-1:0];
            wr_data  = cur_ff.box;
            count_in = count_ff + CNT_BITS'(1);
         end
         BK_EMIT: begin
            emit_idx_in = emit_idx_ff;
            rd_valid_in = issue;
            if (issue) begin
               rd_a_addr   = emit_idx_ff[IDX_BITS-1:0];
               rd_b_addr   = nb_idx[IDX_BITS-1:0];
               emit_idx_in = idx_next;
            end
            // one crop held back so the final one can carry the last mark
            if (rd_valid_ff && qualify) begin
               if (pend_valid_ff) begin
                  out_strobe_in = 1'b1;
                  out_in        = pend_ff;
               end
               pend_in       = new_crop;
               pend_valid_in = 1'b1;
            end
         end
         BK_FLUSH: begin
            out_strobe_in = 1'b1;
            if (pend_valid_ff) begin
               out_in = pend_ff;
            end else begin
               out_in = '0;
            end
            out_in.last   = 1'b1;
            pend_valid_in = 1'b0;
            count_in      = '0;
            tallest_in    = '0;
         end
         default: begin
            pend_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         count_ff      <= '0;
         tallest_ff    <= '0;
         emit_idx_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         tallest_ff    <= tallest_in;
         emit_idx_ff   <= emit_idx_in;
         rd_valid_ff   <= rd_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_strobe_ff <= out_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      cur_ff  <= cur_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= store_ff[rd_a_addr];
      rd_b_ff <= store_ff[rd_b_addr];
   end

   assign out_strobe = out_strobe_ff;
   assign out_crop   = out_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_BOXES))
      else $error("box count beyond store depth");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_FLUSH |=> count_ff == '0 && tallest_ff == '0 && !pend_valid_ff)
      else $error("frame state not cleared after flush");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      out_strobe_ff && out_ff.last |-> state_ff == BK_IDLE)
      else $error("final crop sent while sequencer busy");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == BK_IDLE && queue_valid)
      else $error("request popped outside idle");

endmodule

// File: sim/tb_plate_character_box_selector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_plate_character_box_selector_core
// Self-checking bench for the plate character box selector. A driver feeds
// candidate-box requests from a queue; an internal predictor mirrors the
// keep tests, sorted store and end-of-frame crop selection, and a monitor
// compares every crop strobe against the oldest predicted crop. Register
// settings are changed between idle phases, extremes included.
// ----------------------------------------------------------------------------
module tb_plate_character_box_selector_core;
   import pcbs_pkg::*;

   localparam int SETTLE_CYCLES = 120;

   typedef struct packed {
      logic    present;
      logic    last;
      box_type box;
   } req_item_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_box_present = 1'b0;
   logic [COORD_BITS-1:0]    req_box_x = '0;
   logic [COORD_BITS-1:0]    req_box_y = '0;
   logic [COORD_BITS-1:0]    req_box_width = '0;
   logic [COORD_BITS-1:0]    req_box_height = '0;
   logic [COORD_BITS-1:0]    req_centroid_col = '0;
   logic                     req_last_box = 1'b0;
   logic                     rsp_strobe;
   logic                     rsp_crop_valid;
   logic [COORD_BITS-1:0]    rsp_crop_x;
   logic [COORD_BITS-1:0]    rsp_crop_y;
   logic [COORD_BITS-1:0]    rsp_crop_width;
   logic [HGT_BITS-1:0]      rsp_crop_height;
   logic                     rsp_last_crop;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_write_data = '0;

   csr_type      csr_shadow;
   box_type      held_boxes [MAX_BOXES];
   int           held_count = 0;
   logic [COORD_BITS-1:0] tallest_seen = '0;
   crop_type     crops_due [$];
   req_item_type pending_reqs [$];
   req_item_type cur_req;
   int           hold_off = 0;
   bit           no_idle = 1'b0;
   int           mismatches = 0;

   plate_character_box_selector_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_box_present  (req_box_present),
      .req_box_x        (req_box_x),
      .req_box_y        (req_box_y),
      .req_box_width    (req_box_width),
      .req_box_height   (req_box_height),
      .req_centroid_col (req_centroid_col),
      .req_last_box     (req_last_box),
      .rsp_strobe       (rsp_strobe),
      .rsp_crop_valid   (rsp_crop_valid),
      .rsp_crop_x       (rsp_crop_x),
      .rsp_crop_y       (rsp_crop_y),
      .rsp_crop_width   (rsp_crop_width),
      .rsp_crop_height  (rsp_crop_height),
      .rsp_last_crop    (rsp_last_crop),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t ERROR %s", $realtime, what);
   endtask

   task automatic add_req(req_item_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   function automatic bit box_kept(logic [COORD_BITS-1:0] w, logic [COORD_BITS-1:0] h);
      longint lng, sht;
      lng = (h > w) ? longint'(h) : longint'(w);
      sht = (h > w) ? longint'(w) : longint'(h);
      return (lng * 10 < longint'(csr_shadow.ratio_limit_tenths) * sht) &&
             (longint'(h) * 1000 >
              longint'(csr_shadow.min_height_pct_tenths) * longint'(csr_shadow.image_rows)) &&
             (longint'(w) * 1000 >
              longint'(csr_shadow.min_width_pct_tenths) * longint'(csr_shadow.image_cols));
   endfunction

   // keep tests, sorted insert and end-of-frame crop selection
   task automatic predict_crops(req_item_type r);
      int       pos, k, n;
      logic [COORD_BITS-1:0] diff;
      crop_type c;
      if (r.present && box_kept(r.box.w, r.box.h) && held_count < MAX_BOXES) begin
         if (r.box.h > tallest_seen) tallest_seen = r.box.h;
         pos = held_count;
         while (pos > 0 && held_boxes[pos-1].cx > r.box.cx) begin
            held_boxes[pos] = held_boxes[pos-1];
            pos--;
         end
         held_boxes[pos] = r.box;
         held_count++;
      end
      if (!r.last) return;
      n = 0;
      for (int i = 0; i < held_count; i++) begin
         if (int'(held_boxes[i].h) * 2 < int'(tallest_seen)) continue;
         diff = (tallest_seen > held_boxes[i].h) ? tallest_seen - held_boxes[i].h
                                                 : held_boxes[i].h - tallest_seen;
         c.valid = 1'b1;
         c.x     = held_boxes[i].x;
         c.y     = held_boxes[i].y;
         c.w     = held_boxes[i].w;
         c.h     = {1'b0, held_boxes[i].h};
         c.last  = 1'b0;
         if (diff > csr_shadow.height_variation_limit) begin
            if (i + 1 < held_count) k = i + 1;
            else if (i > 0)         k = i - 1;
            else                    k = i;
            c.y = (held_boxes[k].y >= COORD_BITS'(EXPAND_MARGIN))
                  ? held_boxes[k].y - COORD_BITS'(EXPAND_MARGIN) : '0;
            c.h = {1'b0, held_boxes[k].h} + HGT_BITS'(EXPAND_MARGIN);
         end
         crops_due.insert(crops_due.size(), c);
         n++;
      end
      if (n == 0) begin
         c = '0;
      end else begin
         c = crops_due.pop_back();
      end
      c.last = 1'b1;
      crops_due.insert(crops_due.size(), c);
      held_count   = 0;
      tallest_seen = '0;
   endtask

   always @(posedge clock) begin : driver
      if (reset) begin
         start    <= 1'b0;
         hold_off = 0;
      end else begin
         if (start && !busy) begin
            predict_crops(cur_req);
            hold_off = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         end
         if (!start || !busy) begin
            if (hold_off > 0) begin
               hold_off--;
               start <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               cur_req = pending_reqs.pop_front();
               start            <= 1'b1;
               req_box_present  <= cur_req.present;
               req_box_x        <= cur_req.box.x;
               req_box_y        <= cur_req.box.y;
               req_box_width    <= cur_req.box.w;
               req_box_height   <= cur_req.box.h;
               req_centroid_col <= cur_req.box.cx;
               req_last_box     <= cur_req.last;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      crop_type got, want;
      if (!reset && rsp_strobe) begin
         got = '{rsp_crop_valid, rsp_crop_x, rsp_crop_y, rsp_crop_width,
                 rsp_crop_height, rsp_last_crop};
         if (crops_due.size() == 0) begin
            flag($sformatf("unexpected crop v=%0d x=%0d y=%0d w=%0d h=%0d last=%0d",
                           got.valid, got.x, got.y, got.w, got.h, got.last));
         end else begin
            want = crops_due.pop_front();
            if (got.valid !== want.valid || got.x !== want.x || got.y !== want.y ||
                got.w !== want.w || got.h !== want.h || got.last !== want.last)
               flag($sformatf({"crop mismatch: expected v=%0d x=%0d y=%0d w=%0d h=%0d ",
                               "last=%0d, got v=%0d x=%0d y=%0d w=%0d h=%0d last=%0d"},
                              want.valid, want.x, want.y, want.w, want.h, want.last,
                              got.valid, got.x, got.y, got.w, got.h, got.last));
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, int value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value[CSR_DATA_BITS-1:0];
      case (idx)
         CSR_RATIO_LIMIT: csr_shadow.ratio_limit_tenths     = value[RATIO_BITS-1:0];
         CSR_MIN_HEIGHT:  csr_shadow.min_height_pct_tenths  = value[PCT_BITS-1:0];
         CSR_MIN_WIDTH:   csr_shadow.min_width_pct_tenths   = value[PCT_BITS-1:0];
         CSR_VAR_LIMIT:   csr_shadow.height_variation_limit = value[COORD_BITS-1:0];
         CSR_IMAGE_ROWS:  csr_shadow.image_rows             = value[COORD_BITS-1:0];
         CSR_IMAGE_COLS:  csr_shadow.image_cols             = value[COORD_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic apply_setting(int ratio, int min_h, int min_w, int var_lim,
                                int rows, int cols);
      write_reg(CSR_RATIO_LIMIT, ratio);
      write_reg(CSR_MIN_HEIGHT, min_h);
      write_reg(CSR_MIN_WIDTH, min_w);
      write_reg(CSR_VAR_LIMIT, var_lim);
      write_reg(CSR_IMAGE_ROWS, rows);
      write_reg(CSR_IMAGE_COLS, cols);
   endtask

   // block idle: everything sent, every crop in, then let it flush
   task automatic settle();
      while (pending_reqs.size() != 0 || start || crops_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int min_kept_side(longint pct, longint dim);
      longint side;
      side = pct * dim / 1000 + 1;
      return (side > 4095) ? 4095 : int'(side);
   endfunction

   function automatic req_item_type mk(bit present, int x, int y, int w, int h, int cx,
                                       bit last);
      req_item_type r;
      r.present = present;
      r.last    = last;
      r.box     = '{x[11:0], y[11:0], w[11:0], h[11:0], cx[11:0]};
      return r;
   endfunction

   function automatic box_type draw_kept_box(int base_h, int spread, bit ties);
      box_type b;
      longint  w_lo, w_hi, lo_w;
      int      h_top;
      lo_w  = min_kept_side(csr_shadow.min_width_pct_tenths, csr_shadow.image_cols);
      h_top = (base_h + spread > 4095) ? 4095 : base_h + spread;
      for (int t = 0; t < 8; t++) begin
         b.h  = COORD_BITS'($urandom_range(base_h, h_top));
         w_lo = longint'(b.h) * 10 / csr_shadow.ratio_limit_tenths + 1;
         if (w_lo < lo_w) w_lo = lo_w;
         if (w_lo > 4095) w_lo = 4095;
         w_hi = (longint'(b.h) * csr_shadow.ratio_limit_tenths - 1) / 10;
         if (w_hi > 4095) w_hi = 4095;
         if (w_hi < w_lo) w_hi = w_lo;
         b.w = COORD_BITS'($urandom_range(int'(w_lo), int'(w_hi)));
         if (box_kept(b.w, b.h)) break;
      end
      b.x  = COORD_BITS'($urandom_range(0, 4095));
      b.y  = COORD_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 5)
                                                     : $urandom_range(0, 4095));
      b.cx = COORD_BITS'(ties ? $urandom_range(0, 7) : $urandom_range(0, 4095));
      return b;
   endfunction

   task automatic queue_frame(int boxes, bit clean, output int count);
      int           h_floor, base_h, spread, roll;
      bit           ties;
      req_item_type r;
      h_floor = min_kept_side(csr_shadow.min_height_pct_tenths, csr_shadow.image_rows);
      base_h  = $urandom_range(h_floor, (h_floor + 400 > 4095) ? 4095 : h_floor + 400);
      spread  = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(50, 400);
      ties    = ($urandom_range(0, 3) == 0);
      for (int j = 0; j <= boxes; j++) begin
         roll      = clean ? 9 : $urandom_range(0, 9);
         r.present = (roll != 0);
         r.last    = (j == boxes);
         if (roll <= 1)
            r.box = '{COORD_BITS'($urandom_range(0, 4095)),
                      COORD_BITS'($urandom_range(0, 4095)),
                      COORD_BITS'($urandom_range(1, 4095)),
                      COORD_BITS'($urandom_range(1, 4095)),
                      COORD_BITS'($urandom_range(0, 4095))};
         else
            r.box = draw_kept_box(base_h, spread, ties);
         if (r.last && !clean && $urandom_range(0, 6) == 0) r.present = 1'b0;
         add_req(r);
      end
      count = boxes + 1;
   endtask

   task automatic queue_random(int quota, bit with_long);
      int queued, n;
      queued = 0;
      if (with_long) begin
         queue_frame($urandom_range(34, 40), 1'b1, n);
         queued += n;
      end
      while (queued < quota) begin
         queue_frame($urandom_range(0, 9), 1'b0, n);
         queued += n;
      end
   endtask

   initial begin : stimulus
      csr_shadow = '{8'd32, 10'd144, 10'd50, 12'd7, 12'd480, 12'd640};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // item without box, no end of frame
      add_req(mk(0, 4095, 4095, 4095, 4095, 4095, 0));
      // bare end marker on an empty frame
      add_req(mk(0, 0, 0, 0, 0, 0, 1));
      // zero width is never kept
      add_req(mk(1, 10, 20, 0, 100, 50, 1));
      // lone box
      add_req(mk(1, 0, 2, 50, 100, 0, 1));
      // expansion from right neighbour, y clamp, max height
      add_req(mk(1, 100, 2, 1500, 3000, 5, 0));
      add_req(mk(1, 4095, 3, 2000, 4095, 10, 1));
      // centroid ties, half-height skip, final box uses left neighbour
      add_req(mk(1, 10, 4095, 100, 200, 1, 0));
      add_req(mk(1, 20, 50, 100, 150, 1, 0));
      add_req(mk(1, 30, 60, 80, 180, 0, 0));
      add_req(mk(1, 40, 70, 60, 90, 4095, 0));
      add_req(mk(1, 50, 80, 60, 120, 4095, 1));
      // ratio fail, then end marker closing a frame with one box
      add_req(mk(1, 5, 5, 40, 1000, 100, 0));
      add_req(mk(1, 6, 6, 60, 150, 200, 0));
      add_req(mk(0, 4095, 0, 4095, 0, 4095, 1));
      // size limits just missed, last request not kept
      add_req(mk(1, 7, 7, 40, 69, 300, 0));
      add_req(mk(1, 8, 8, 32, 80, 301, 1));
      settle();

      queue_random(60, 1'b1);
      settle();

      apply_setting(255, 0, 0, 0, 4095, 4095);
      no_idle = 1'b1;
      queue_random(60, 1'b0);
      settle();

      apply_setting(10, 1000, 1000, 4095, 1, 1);
      no_idle = 1'b0;
      queue_random(25, 1'b0);
      settle();

      apply_setting(20, 500, 100, 30, 200, 300);
      queue_random(60, 1'b1);
      settle();

      // zero image size
      apply_setting(40, 0, 1000, 4095, 0, 0);
      no_idle = 1'b1;
      queue_random(50, 1'b0);
      settle();

      apply_setting(32, 144, 50, 7, 480, 640);
      no_idle = 1'b0;
      queue_random(40, 1'b0);
      settle();

      if (mismatches == 0 && crops_due.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: filelist.f
rtl/pcbs_pkg.sv
rtl/pcbs_front.sv
rtl/pcbs_queue.sv
rtl/pcbs_back.sv
rtl/plate_character_box_selector_core.sv
sim/tb_plate_character_box_selector_core.sv
